// File: src/sms_pkg.sv
// Shared constants, types and helpers of the spiral matrix scan block.
`default_nettype none
package sms_pkg;

  // Matrix geometry and element width
  localparam int MAX_DIM     = 64;
  localparam int VAL_W       = 32;
  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int REG_W       = DIM_W + 1;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // Front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Effective matrix size, seen by the front
  typedef struct packed {
    logic [REG_W-1:0] rows;
    logic [REG_W-1:0] cols;
    logic [CNT_W-1:0] total;
  } sms_dims_t;

  // One store operation queued for the back
  typedef struct packed {
    logic              is_read;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
    logic [DIM_W-1:0]  row;
    logic [DIM_W-1:0]  col;
    logic              last;
  } sms_op_t;

  // Map a written dimension into 1..MAX_DIM
  function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] r);
    logic [REG_W-1:0] res;
    res = r;
    if (r == '0) begin
      res = REG_W'(1);
    end else if (r > REG_W'(MAX_DIM)) begin
      res = REG_W'(MAX_DIM);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: src/sms_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module sms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/sms_front.sv
// Front end: accepts beats, tracks load and spiral position, queues store operations.
`default_nettype none
module sms_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     restart_i,
  input  wire sms_pkg::sms_dims_t       dims_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     kind_i,
  input  wire logic [sms_pkg::VAL_W-1:0] value_i,
  output logic                          push_o,
  output sms_pkg::sms_op_t              op_o,
  input  wire logic                     full_i
);
  import sms_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  localparam logic [1:0] HEAD_RIGHT = 2'd0;
  localparam logic [1:0] HEAD_DOWN  = 2'd1;
  localparam logic [1:0] HEAD_LEFT  = 2'd2;
  localparam logic [1:0] HEAD_UP    = 2'd3;

  logic [CNT_W-1:0] loaded_q, loaded_d, emitted_q, emitted_d;
  logic [DIM_W-1:0] top_q, top_d, bot_q, bot_d, left_q, left_d, right_q, right_d;
  logic [DIM_W-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]       head_q, head_d;

  logic             accept;
  logic             load_ok, emit_ok;
  logic [CNT_W-1:0] loaded_inc, emitted_inc;
  logic             fin;
  logic [ADDR_W-1:0] rd_addr;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the beat
  assign load_ok = (kind_i == KIND_LOAD) && (loaded_q < dims_i.total);
  assign emit_ok = (kind_i == KIND_EMIT) && (loaded_q == dims_i.total)
                   && (emitted_q < dims_i.total);

  assign loaded_inc  = loaded_q + CNT_W'(1);
  assign emitted_inc = emitted_q + CNT_W'(1);
  assign fin         = (emitted_inc == dims_i.total);

  // Row-major address of the current spiral position
  assign rd_addr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(dims_i.cols)) + ADDR_W'(col_q);

  // Build the queued operation
  always_comb begin
    push_o = accept && (load_ok || emit_ok) && !restart_i;
    op_o.is_read = emit_ok;
    op_o.addr    = emit_ok ? rd_addr : loaded_q[ADDR_W-1:0];
    op_o.data    = value_i;
    op_o.row     = row_q;
    op_o.col     = col_q;
    op_o.last    = fin;
  end

  // Next state of the load counter and spiral walker
  always_comb begin
    loaded_d  = loaded_q;
    emitted_d = emitted_q;
    top_d     = top_q;
    bot_d     = bot_q;
    left_d    = left_q;
    right_d   = right_q;
    row_d     = row_q;
    col_d     = col_q;
    head_d    = head_q;
    if (restart_i) begin
      loaded_d  = '0;
      emitted_d = '0;
      top_d     = '0;
      bot_d     = '0;
      left_d    = '0;
      right_d   = '0;
      row_d     = '0;
      col_d     = '0;
      head_d    = HEAD_RIGHT;
    end else if (accept && load_ok) begin
      loaded_d = loaded_inc;
      // Matrix complete: arm the walker
      if (loaded_inc == dims_i.total) begin
        top_d     = '0;
        left_d    = '0;
        bot_d     = DIM_W'(dims_i.rows - REG_W'(1));
        right_d   = DIM_W'(dims_i.cols - REG_W'(1));
        row_d     = '0;
        col_d     = '0;
        head_d    = HEAD_RIGHT;
        emitted_d = '0;
      end
    end else if (accept && emit_ok) begin
      if (fin) begin
        // Spiral done: drop back to loading
        loaded_d  = '0;
        emitted_d = '0;
        top_d     = '0;
        bot_d     = '0;
        left_d    = '0;
        right_d   = '0;
        row_d     = '0;
        col_d     = '0;
        head_d    = HEAD_RIGHT;
      end else begin
        emitted_d = emitted_inc;
        case (head_q)
          HEAD_RIGHT: begin
            if (col_q < right_q) begin
              col_d = col_q + DIM_W'(1);
            end else begin
              top_d  = top_q + DIM_W'(1);
              head_d = HEAD_DOWN;
              row_d  = row_q + DIM_W'(1);
            end
          end
          HEAD_DOWN: begin
            if (row_q < bot_q) begin
              row_d = row_q + DIM_W'(1);
            end else begin
              right_d = right_q - DIM_W'(1);
              head_d  = HEAD_LEFT;
              col_d   = col_q - DIM_W'(1);
            end
          end
          HEAD_LEFT: begin
            if (col_q > left_q) begin
              col_d = col_q - DIM_W'(1);
            end else begin
              bot_d  = bot_q - DIM_W'(1);
              head_d = HEAD_UP;
              row_d  = row_q - DIM_W'(1);
            end
          end
          HEAD_UP: begin
            if (row_q > top_q) begin
              row_d = row_q - DIM_W'(1);
            end else begin
              left_d = left_q + DIM_W'(1);
              head_d = HEAD_RIGHT;
              col_d  = col_q + DIM_W'(1);
            end
          end
          default: begin
            head_d = HEAD_RIGHT;
          end
        endcase
      end
    end
  end

  // Hold walker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q  <= '0;
      emitted_q <= '0;
      top_q     <= '0;
      bot_q     <= '0;
      left_q    <= '0;
      right_q   <= '0;
      row_q     <= '0;
      col_q     <= '0;
      head_q    <= HEAD_RIGHT;
    end else begin
      loaded_q  <= loaded_d;
      emitted_q <= emitted_d;
      top_q     <= top_d;
      bot_q     <= bot_d;
      left_q    <= left_d;
      right_q   <= right_d;
      row_q     <= row_d;
      col_q     <= col_d;
      head_q    <= head_d;
    end
  end

endmodule
`default_nettype wire

// File: src/sms_queue.sv
// Short FIFO of store operations between the front and the back.
`default_nettype none
module sms_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sms_pkg::sms_op_t push_op_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output sms_pkg::sms_op_t      head_o
);
  import sms_pkg::*;

  sms_op_t              ent_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_q];

  // Advance pointers and fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_op_i;
    end
  end

endmodule
`default_nettype wire

// File: src/sms_back.sv
// Back end: carries out store writes and reads, holds the result beat.
`default_nettype none
module sms_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_valid_i,
  input  wire sms_pkg::sms_op_t          q_op_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [sms_pkg::VAL_W-1:0]      elem_value_o,
  output logic [sms_pkg::DIM_W-1:0]      elem_row_o,
  output logic [sms_pkg::DIM_W-1:0]      elem_col_o,
  output logic                           last_o
);
  import sms_pkg::*;

  logic              rd_pend_q;
  logic [DIM_W-1:0]  pend_row_q, pend_col_q;
  logic              pend_last_q;
  logic              out_valid_q;
  logic [VAL_W-1:0]  value_q;
  logic [DIM_W-1:0]  row_q, col_q;
  logic              last_q;
  logic              rd_slot_free;
  logic              ram_we, ram_re;
  logic [VAL_W-1:0]  ram_rdata;

  // A read may issue once the output register will be free when its data lands
  assign rd_slot_free = !rd_pend_q && (!out_valid_q || out_ready_i);
  assign q_pop_o = q_valid_i && (!q_op_i.is_read || rd_slot_free);
  assign ram_we  = q_pop_o && !q_op_i.is_read;
  assign ram_re  = q_pop_o && q_op_i.is_read;

  sms_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (q_op_i.addr),
    .wdata_i(q_op_i.data),
    .rdata_o(ram_rdata)
  );

  // Track the read in flight and the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= ram_re;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Carry position and payload
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      pend_row_q  <= q_op_i.row;
      pend_col_q  <= q_op_i.col;
      pend_last_q <= q_op_i.last;
    end
    if (rd_pend_q) begin
      value_q <= ram_rdata;
      row_q   <= pend_row_q;
      col_q   <= pend_col_q;
      last_q  <= pend_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign elem_value_o = value_q;
  assign elem_row_o   = row_q;
  assign elem_col_o   = col_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

// File: src/spiral_matrix_scan_core.sv
// Top level of the spiral matrix scan: configuration registers and the front/back pipeline.
`default_nettype none
// Load beats (kind 0) fill a num_rows x num_cols matrix row-major into a 4096-word
// store; once full, each emit beat (kind 1) returns the next element in clockwise
// spiral order with its row, column and a last mark, after which loading starts over.
// Emit beats before the matrix is complete or extra loads are accepted and dropped.
// The back end cannot start an emit read before the previous one has returned its
// data, set by the single store port and the one-deep read tracking; a two-entry queue
// separates the front (position tracking, address multiply) from the back. A result
// passes through the queue, the store read register and the output register. Writing
// either dimension register discards the matrix in progress; dimensions of 0 act as 1
// and above 64 as 64. The store is not cleared after reset.
module spiral_matrix_scan_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sms_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [sms_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [sms_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           kind_i,
  input  wire logic signed [sms_pkg::VAL_W-1:0] value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [sms_pkg::VAL_W-1:0]    elem_value_o,
  output logic      [sms_pkg::DIM_W-1:0]      elem_row_o,
  output logic      [sms_pkg::DIM_W-1:0]      elem_col_o,
  output logic                                last_o
);
  import sms_pkg::*;

  logic [REG_W-1:0] num_rows_q, num_cols_q;
  logic             cfg_wr;
  sms_dims_t        dims;
  logic             push, full, q_valid, q_pop;
  sms_op_t          push_op, q_head;
  logic [VAL_W-1:0] out_value;

  // Decode configuration writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= REG_W'(1);
      num_cols_q <= REG_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NUM_ROWS) begin
        num_rows_q <= pwdata[REG_W-1:0];
      end else begin
        num_cols_q <= pwdata[REG_W-1:0];
      end
    end
  end

  // Return register values
  assign prdata = (paddr[2] == REG_NUM_COLS) ? APB_DATA_W'(num_cols_q)
                                             : APB_DATA_W'(num_rows_q);

  // Effective matrix size
  always_comb begin
    dims.rows  = clamp_dim(num_rows_q);
    dims.cols  = clamp_dim(num_cols_q);
    dims.total = CNT_W'(CNT_W'(dims.rows) * CNT_W'(dims.cols));
  end

  sms_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .dims_i    (dims),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .kind_i    (kind_i),
    .value_i   (value_i),
    .push_o    (push),
    .op_o      (push_op),
    .full_i    (full)
  );

  sms_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .push_op_i(push_op),
    .full_o   (full),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .head_o   (q_head)
  );

  sms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .elem_value_o(out_value),
    .elem_row_o  (elem_row_o),
    .elem_col_o  (elem_col_o),
    .last_o      (last_o)
  );

  assign elem_value_o = out_value;

endmodule
`default_nettype wire
